FILE: hw/rtl/dcmt_pkg.sv
// shared types and constants for the demand chunk map tracker
`default_nettype none

package dcmt_pkg;

    // table geometry
    localparam int TABLE_SLOTS = 4096;
    localparam int TBL_BITS    = $clog2(TABLE_SLOTS);

    // chunk geometry
    localparam int CHUNK_SHIFT = 16;
    localparam int ADDR_W      = 64;
    localparam int LEN_W       = 22;
    localparam int CHUNK_W     = ADDR_W - CHUNK_SHIFT;
    localparam int KEY_W       = CHUNK_W + 1;
    localparam int CID_W       = 48;

    // span limit per access
    localparam int MAX_SPAN    = 64;
    localparam int IDX_W       = $clog2(MAX_SPAN + 1);

    // multiplicative hash constant and reset limit
    localparam logic [63:0] HASH_MULT       = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] LOW_LIMIT_RESET = 64'h0000_0001_0000_0000;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_DECIDE,
        S_HASH,
        S_READ,
        S_CHECK
    } t_state;

    // kind of result loaded into the output register
    typedef enum logic [2:0] {
        RES_EMPTY,
        RES_BELOW,
        RES_ADDED,
        RES_PRESENT,
        RES_FULL
    } t_res_kind;

    // controller to datapath commands
    typedef struct packed {
        logic      clr_wr;
        logic      load_in;
        logic      prep;
        logic      hash;
        logic      probe_next;
        logic      ins_wr;
        logic      chunk_next;
        logic      out_load;
        t_res_kind out_kind;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic zero_len;
        logic below;
        logic empty_hit;
        logic key_hit;
        logic probe_last;
        logic is_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: hw/rtl/dcmt_dp.sv
// datapath: input registers, span tracking, hash, probe table memory, result register
`default_nettype none

module dcmt_dp (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire dcmt_pkg::t_dp_cmd         i_cmd,
    output dcmt_pkg::t_dp_sts              o_sts,
    input  wire logic                      i_cfg_we,
    input  wire logic [63:0]               i_cfg_wdata,
    input  wire logic [dcmt_pkg::ADDR_W-1:0] i_addr,
    input  wire logic [dcmt_pkg::LEN_W-1:0]  i_length,
    input  wire logic                      i_out_ready,
    output logic                           o_out_valid,
    output logic [dcmt_pkg::CID_W-1:0]     o_chunk_num,
    output logic                           o_newly_added,
    output logic                           o_below_limit,
    output logic                           o_table_full,
    output logic                           o_empty_access,
    output logic                           o_last
);

    // low limit register
    logic [63:0] r_low_limit;

    // request registers and span state
    logic [dcmt_pkg::ADDR_W-1:0]  r_addr;
    logic [dcmt_pkg::LEN_W-1:0]   r_len;
    logic                         r_zero;
    logic                         r_below;
    logic [dcmt_pkg::CHUNK_W-1:0] r_chunk;
    logic [dcmt_pkg::CHUNK_W-1:0] r_c1;
    logic [dcmt_pkg::IDX_W-1:0]   r_idx;
    logic                         r_is_last;

    // probe state
    logic [dcmt_pkg::TBL_BITS-1:0] r_slot;
    logic [dcmt_pkg::TBL_BITS-1:0] r_probe;
    logic [dcmt_pkg::TBL_BITS-1:0] n_slot;

    // table memory
    logic [dcmt_pkg::KEY_W-1:0] r_mem [dcmt_pkg::TABLE_SLOTS];
    logic [dcmt_pkg::KEY_W-1:0] r_rd_data;
    logic                       wr_en;
    logic [dcmt_pkg::KEY_W-1:0] wr_data;

    // result register
    logic                         r_out_valid;
    logic [dcmt_pkg::CHUNK_W-1:0] r_out_chunk;
    logic                         r_out_added;
    logic                         r_out_below;
    logic                         r_out_full;
    logic                         r_out_empty;
    logic                         r_out_last;

    // combinational helpers
    logic [dcmt_pkg::ADDR_W:0]       end_sum;
    logic [dcmt_pkg::ADDR_W-1:0]     end_addr;
    logic [dcmt_pkg::KEY_W-1:0]      key;
    logic [dcmt_pkg::TBL_BITS-1:0]   hash_prod;
    logic                            out_free;

    // end address, saturated at the top of the address space
    assign end_sum  = {1'b0, r_addr} + (dcmt_pkg::ADDR_W + 1)'(r_len)
                    - (dcmt_pkg::ADDR_W + 1)'(1);
    assign end_addr = end_sum[dcmt_pkg::ADDR_W] ? '1 : end_sum[dcmt_pkg::ADDR_W-1:0];

    // stored key is chunk plus one, zero marks an empty slot
    assign key       = {1'b0, r_chunk} + dcmt_pkg::KEY_W'(1);
    // home slot only needs the low bits of the product
    assign hash_prod = r_chunk[dcmt_pkg::TBL_BITS-1:0]
                     * dcmt_pkg::HASH_MULT[dcmt_pkg::TBL_BITS-1:0];
    assign out_free  = !r_out_valid || i_out_ready;

    // memory write select
    assign wr_en   = i_cmd.clr_wr || i_cmd.ins_wr;
    assign wr_data = i_cmd.clr_wr ? '0 : key;

    // low limit, writable at any time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_limit <= dcmt_pkg::LOW_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_low_limit <= i_cfg_wdata;
        end
    end

    // request capture and span bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_addr <= i_addr;
            r_len  <= i_length;
        end
        if (i_cmd.prep) begin
            r_zero  <= (r_len == '0);
            r_below <= (r_addr < r_low_limit);
            r_chunk <= r_addr[dcmt_pkg::ADDR_W-1:dcmt_pkg::CHUNK_SHIFT];
            r_c1    <= end_addr[dcmt_pkg::ADDR_W-1:dcmt_pkg::CHUNK_SHIFT];
            r_idx   <= '0;
        end else if (i_cmd.chunk_next) begin
            r_chunk <= r_chunk + dcmt_pkg::CHUNK_W'(1);
            r_idx   <= r_idx + dcmt_pkg::IDX_W'(1);
        end
        if (i_cmd.hash) begin
            r_is_last <= (r_chunk == r_c1)
                      || (r_idx == dcmt_pkg::IDX_W'(dcmt_pkg::MAX_SPAN - 1));
        end
    end

    // slot pointer: clearing sweep, home slot, linear probe with wrap
    always_comb begin
        n_slot = r_slot;
        priority if (i_cmd.clr_wr) begin
            n_slot = r_slot + dcmt_pkg::TBL_BITS'(1);
        end else if (i_cmd.hash) begin
            n_slot = hash_prod;
        end else if (i_cmd.probe_next) begin
            n_slot = r_slot + dcmt_pkg::TBL_BITS'(1);
        end else begin
            n_slot = r_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else begin
            r_slot <= n_slot;
        end
    end

    // probe counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.hash) begin
            r_probe <= '0;
        end else if (i_cmd.probe_next) begin
            r_probe <= r_probe + dcmt_pkg::TBL_BITS'(1);
        end
    end

    // table memory, one port, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_slot] <= wr_data;
        end
        r_rd_data <= r_mem[r_slot];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            unique case (i_cmd.out_kind)
                dcmt_pkg::RES_EMPTY, dcmt_pkg::RES_BELOW: begin
                    r_out_chunk <= '0;
                    r_out_added <= 1'b0;
                    r_out_below <= (i_cmd.out_kind == dcmt_pkg::RES_BELOW);
                    r_out_full  <= 1'b0;
                    r_out_empty <= (i_cmd.out_kind == dcmt_pkg::RES_EMPTY);
                    r_out_last  <= 1'b1;
                end
                default: begin
                    r_out_chunk <= r_chunk;
                    r_out_added <= (i_cmd.out_kind == dcmt_pkg::RES_ADDED);
                    r_out_below <= 1'b0;
                    r_out_full  <= (i_cmd.out_kind == dcmt_pkg::RES_FULL);
                    r_out_empty <= 1'b0;
                    r_out_last  <= r_is_last;
                end
            endcase
        end
    end

    // status back to the controller
    always_comb begin
        o_sts.clr_last   = (r_slot == '1);
        o_sts.zero_len   = r_zero;
        o_sts.below      = r_below;
        o_sts.empty_hit  = (r_rd_data == '0);
        o_sts.key_hit    = (r_rd_data == key);
        o_sts.probe_last = (r_probe == '1);
        o_sts.is_last    = r_is_last;
        o_sts.out_free   = out_free;
    end

    // result ports
    assign o_out_valid    = r_out_valid;
    assign o_chunk_num    = dcmt_pkg::CID_W'(r_out_chunk);
    assign o_newly_added  = r_out_added;
    assign o_below_limit  = r_out_below;
    assign o_table_full   = r_out_full;
    assign o_empty_access = r_out_empty;
    assign o_last         = r_out_last;

endmodule

`default_nettype wire

FILE: hw/rtl/dcmt_ctrl.sv
// controller: clearing sweep, request sequencing and probe loop
`default_nettype none

module dcmt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire dcmt_pkg::t_dp_sts i_sts,
    output dcmt_pkg::t_dp_cmd      o_cmd
);

    dcmt_pkg::t_state r_state;
    dcmt_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dcmt_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.out_kind = dcmt_pkg::RES_PRESENT;
        unique case (r_state)
            dcmt_pkg::S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = dcmt_pkg::S_IDLE;
                end
            end
            dcmt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = dcmt_pkg::S_PREP;
                end
            end
            dcmt_pkg::S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = dcmt_pkg::S_DECIDE;
            end
            dcmt_pkg::S_DECIDE: begin
                // zero length wins over the limit check
                priority if (i_sts.zero_len) begin
                    if (i_sts.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_kind = dcmt_pkg::RES_EMPTY;
                        n_state        = dcmt_pkg::S_IDLE;
                    end
                end else if (i_sts.below) begin
                    if (i_sts.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_kind = dcmt_pkg::RES_BELOW;
                        n_state        = dcmt_pkg::S_IDLE;
                    end
                end else begin
                    n_state = dcmt_pkg::S_HASH;
                end
            end
            dcmt_pkg::S_HASH: begin
                o_cmd.hash = 1'b1;
                n_state    = dcmt_pkg::S_READ;
            end
            dcmt_pkg::S_READ: begin
                // slot read in flight
                n_state = dcmt_pkg::S_CHECK;
            end
            dcmt_pkg::S_CHECK: begin
                priority if (i_sts.empty_hit || i_sts.key_hit || i_sts.probe_last) begin
                    if (i_sts.out_free) begin
                        o_cmd.out_load = 1'b1;
                        priority if (i_sts.empty_hit) begin
                            o_cmd.ins_wr   = 1'b1;
                            o_cmd.out_kind = dcmt_pkg::RES_ADDED;
                        end else if (i_sts.key_hit) begin
                            o_cmd.out_kind = dcmt_pkg::RES_PRESENT;
                        end else begin
                            o_cmd.out_kind = dcmt_pkg::RES_FULL;
                        end
                        if (i_sts.is_last) begin
                            n_state = dcmt_pkg::S_IDLE;
                        end else begin
                            o_cmd.chunk_next = 1'b1;
                            n_state          = dcmt_pkg::S_HASH;
                        end
                    end
                end else begin
                    o_cmd.probe_next = 1'b1;
                    n_state          = dcmt_pkg::S_READ;
                end
            end
            default: begin
                n_state = dcmt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/demand_chunk_map_tracker_core.sv
// top level of the demand chunk map tracker: controller plus datapath
//
// channel   direction  handshake                  payload
// request   in         i_in_valid / o_in_ready    i_addr, i_length
// result    out        o_out_valid / i_out_ready  o_chunk_num, flags, o_last
// config    in         i_cfg_we                   i_cfg_wdata (low limit)
//
// after reset a clearing sweep writes every table slot and takes no requests
// a request is set up in the prep and decide states; each chunk then runs hash, read
// and check; each extra probe repeats read and check (single-port table, registered read)
// zero-length and below-limit requests give their one result after setup
// a result waits in an output register; work stalls only when the next one is ready first
`default_nettype none

module demand_chunk_map_tracker_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [63:0]                   i_cfg_wdata,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [dcmt_pkg::ADDR_W-1:0]   i_addr,
    input  wire logic [dcmt_pkg::LEN_W-1:0]    i_length,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [dcmt_pkg::CID_W-1:0]         o_chunk_num,
    output logic                               o_newly_added,
    output logic                               o_below_limit,
    output logic                               o_table_full,
    output logic                               o_empty_access,
    output logic                               o_last
);

    dcmt_pkg::t_dp_cmd cmd;
    dcmt_pkg::t_dp_sts sts;

    // sequencing
    dcmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // storage and arithmetic
    dcmt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_addr         (i_addr),
        .i_length       (i_length),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_chunk_num    (o_chunk_num),
        .o_newly_added  (o_newly_added),
        .o_below_limit  (o_below_limit),
        .o_table_full   (o_table_full),
        .o_empty_access (o_empty_access),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

FILE: verif/tb_demand_chunk_map_tracker_core.sv
// testbench for the demand chunk map tracker core: requests checked against a table model
module tb_demand_chunk_map_tracker_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [dcmt_pkg::LEN_W-1:0]  LEN_TOP     = 22'h3F0000;
    localparam logic [dcmt_pkg::ADDR_W-1:0] WINDOW_BASE = 64'h0000_7F00_0000_0000;
    localparam logic [dcmt_pkg::ADDR_W-1:0] FILL_BASE   = 64'h0000_3C00_0000_0000;
    localparam int                          QUIET_LIMIT = 60000;

    typedef struct packed {
        logic [dcmt_pkg::ADDR_W-1:0] addr;
        logic [dcmt_pkg::LEN_W-1:0]  len;
    } t_access;

    typedef struct packed {
        logic [dcmt_pkg::CID_W-1:0] chunk_num;
        logic                       newly_added;
        logic                       below_limit;
        logic                       table_full;
        logic                       empty_access;
        logic                       last;
    } t_chunk_result;

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_cfg_we       = 1'b0;
    logic [63:0]                   i_cfg_wdata    = '0;
    logic                          i_in_valid     = 1'b0;
    logic                          o_in_ready;
    logic [dcmt_pkg::ADDR_W-1:0]   i_addr         = '0;
    logic [dcmt_pkg::LEN_W-1:0]    i_length       = '0;
    logic                          o_out_valid;
    logic                          i_out_ready    = 1'b0;
    logic [dcmt_pkg::CID_W-1:0]    o_chunk_num;
    logic                          o_newly_added;
    logic                          o_below_limit;
    logic                          o_table_full;
    logic                          o_empty_access;
    logic                          o_last;

    // shadow of the chunk table and the low limit register
    bit   [dcmt_pkg::KEY_W-1:0]    shadow_slots [dcmt_pkg::TABLE_SLOTS];
    int                            slots_used     = 0;
    logic [63:0]                   limit_shadow   = dcmt_pkg::LOW_LIMIT_RESET;

    t_access                       access_queue[$];
    t_chunk_result                 want_results[$];
    int                            send_idle_pct  = 0;
    int                            recv_stall_pct = 0;
    bit                            failed         = 1'b0;
    int                            quiet_cycles   = 0;
    logic [63:0]                   fill_chunk     = '0;

    demand_chunk_map_tracker_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_addr         (i_addr),
        .i_length       (i_length),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_chunk_num    (o_chunk_num),
        .o_newly_added  (o_newly_added),
        .o_below_limit  (o_below_limit),
        .o_table_full   (o_table_full),
        .o_empty_access (o_empty_access),
        .o_last         (o_last)
    );

    always #10 i_clk = ~i_clk;

    // split an accepted request into chunks, probe the shadow table, queue the results
    task automatic predict_access(input logic [dcmt_pkg::ADDR_W-1:0] addr,
                                  input logic [dcmt_pkg::LEN_W-1:0] len);
        t_chunk_result                 r;
        logic [dcmt_pkg::ADDR_W:0]     end_sum;
        logic [dcmt_pkg::ADDR_W-1:0]   end_addr;
        logic [dcmt_pkg::CHUNK_W-1:0]  c_first;
        logic [dcmt_pkg::CHUNK_W-1:0]  c_last;
        logic [dcmt_pkg::CHUNK_W-1:0]  span;
        logic [dcmt_pkg::CHUNK_W-1:0]  c;
        logic [dcmt_pkg::KEY_W-1:0]    key;
        logic [63:0]                   prod;
        logic [dcmt_pkg::TBL_BITS-1:0] slot;
        int                            n;
        r = '0;
        r.last = 1'b1;
        if (len == '0) begin
            // zero length wins over the limit check
            r.empty_access = 1'b1;
            want_results.push_back(r);
        end else if (addr < limit_shadow) begin
            r.below_limit = 1'b1;
            want_results.push_back(r);
        end else begin
            // end address clamps at the top of the address space
            end_sum  = {1'b0, addr} + (dcmt_pkg::ADDR_W + 1)'(len)
                     - (dcmt_pkg::ADDR_W + 1)'(1);
            end_addr = end_sum[dcmt_pkg::ADDR_W] ? '1 : end_sum[dcmt_pkg::ADDR_W-1:0];
            c_first  = addr[dcmt_pkg::ADDR_W-1:dcmt_pkg::CHUNK_SHIFT];
            c_last   = end_addr[dcmt_pkg::ADDR_W-1:dcmt_pkg::CHUNK_SHIFT];
            span     = c_last - c_first;
            n        = (span >= dcmt_pkg::CHUNK_W'(dcmt_pkg::MAX_SPAN))
                     ? dcmt_pkg::MAX_SPAN : int'(span) + 1;
            for (int i = 0; i < n; i++) begin
                c    = c_first + dcmt_pkg::CHUNK_W'(i);
                key  = {1'b0, c} + dcmt_pkg::KEY_W'(1);
                prod = {{(64 - dcmt_pkg::CHUNK_W){1'b0}}, c} * dcmt_pkg::HASH_MULT;
                slot = prod[dcmt_pkg::TBL_BITS-1:0];
                r = '0;
                r.chunk_num  = dcmt_pkg::CID_W'(c);
                r.table_full = 1'b1;
                // linear probe, wrapping, until empty slot or key match
                for (int p = 0; p < dcmt_pkg::TABLE_SLOTS; p++) begin
                    if (shadow_slots[slot] == '0) begin
                        shadow_slots[slot] = key;
                        slots_used++;
                        r.newly_added = 1'b1;
                        r.table_full  = 1'b0;
                        break;
                    end
                    if (shadow_slots[slot] == key) begin
                        r.table_full = 1'b0;
                        break;
                    end
                    slot = slot + dcmt_pkg::TBL_BITS'(1);
                end
                r.last = (i == n - 1);
                want_results.push_back(r);
            end
        end
    endtask

    task automatic queue_access(input logic [dcmt_pkg::ADDR_W-1:0] addr,
                                input logic [dcmt_pkg::LEN_W-1:0] len);
        t_access a;
        a.addr = addr;
        a.len  = len;
        access_queue.push_back(a);
    endtask

    // random request: mostly a small hot window so chunks repeat, plus edge cases and noise
    function automatic t_access rand_access();
        t_access a;
        int      pick;
        int      size_pick;
        pick = $urandom_range(0, 99);
        a.addr = WINDOW_BASE + {40'h0, 8'($urandom_range(0, 255)), 16'h0000}
               + 64'($urandom_range(0, 16'hFFFF));
        size_pick = $urandom_range(0, 99);
        if (size_pick < 75)
            a.len = dcmt_pkg::LEN_W'($urandom_range(1, 22'h2FFFF));
        else if (size_pick < 95)
            a.len = dcmt_pkg::LEN_W'($urandom_range(1, 22'hFFFFF));
        else
            a.len = dcmt_pkg::LEN_W'($urandom_range(1, LEN_TOP));
        if (pick < 7) begin
            a.addr = {$urandom, $urandom};
            a.len  = '0;
        end else if (pick < 14) begin
            a.addr = (limit_shadow == '0) ? '0 : {$urandom, $urandom} % limit_shadow;
            a.len  = dcmt_pkg::LEN_W'($urandom_range(1, LEN_TOP));
        end else if (pick < 20) begin
            a.addr = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 22'h3FFFFF));
            a.len  = dcmt_pkg::LEN_W'($urandom_range(1, LEN_TOP));
        end else if (pick < 30) begin
            a.addr = {$urandom, $urandom};
            a.len  = dcmt_pkg::LEN_W'($urandom_range(1, 22'h3FFFF));
        end else if (pick < 32) begin
            // lengths near the span cap, some of them spanning past it
            a.len  = dcmt_pkg::LEN_W'($urandom_range(22'h3F0001, 22'h3FFFFF));
        end
        return a;
    endfunction

    task automatic run_random(input int count);
        repeat (count) access_queue.push_back(rand_access());
    endtask

    // wait until every request is taken and every result is back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (access_queue.size() != 0 || i_in_valid || want_results.size() != 0);
    endtask

    task automatic write_low_limit(input logic [63:0] value);
        // short hold-off so the core is back in idle
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        limit_shadow = value;
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("[%0t] %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            failed = 1'b1;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        t_access next_req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_access(i_addr, i_length);
            end
            if (!i_in_valid || o_in_ready) begin
                if (access_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_req = access_queue.pop_front();
                    i_in_valid <= 1'b1;
                    i_addr     <= next_req.addr;
                    i_length   <= next_req.len;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_chunk_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (want_results.size() == 0) begin
                    $display("[%0t] unexpected result: chunk %0h", $time, o_chunk_num);
                    failed = 1'b1;
                end else begin
                    want = want_results.pop_front();
                    check_field("chunk_num", 64'(want.chunk_num), 64'(o_chunk_num));
                    check_field("newly_added", 64'(want.newly_added), 64'(o_newly_added));
                    check_field("below_limit", 64'(want.below_limit), 64'(o_below_limit));
                    check_field("table_full", 64'(want.table_full), 64'(o_table_full));
                    check_field("empty_access", 64'(want.empty_access),
                                64'(o_empty_access));
                    check_field("last", 64'(want.last), 64'(o_last));
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("demand_chunk_map_tracker_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin
        int left;
        int n;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests at the reset limit, no idling
        queue_access(64'h0000_0001_0000_0000, 22'd1);
        queue_access(64'h0000_0001_0000_0000, 22'd1);
        queue_access(64'h0000_0000_FFFF_FFFF, 22'd1);
        queue_access(64'h0000_0000_0000_0000, 22'd0);
        queue_access(64'hFFFF_FFFF_FFFF_FFFF, 22'd0);
        queue_access(64'hFFFF_FFFF_FFFF_FFFF, 22'd1);
        // end address runs past the top
        queue_access(64'hFFFF_FFFF_FFFE_8000, 22'h3FFFFF);
        // spans past, at and within the span cap
        queue_access(64'h0000_0002_0000_FFFF, 22'h3FFFFF);
        queue_access(64'h0000_0003_0000_0000, LEN_TOP);
        queue_access(64'h0000_0003_0000_FFFF, LEN_TOP);
        queue_access(64'h0000_0004_0000_FFFF, 22'd2);
        queue_access(64'h0000_0005_0000_0000, 22'h10000);
        queue_access(64'h0000_0005_0000_0000, 22'h10001);
        // chunks 4096 apart share a home slot
        queue_access(64'h0000_0006_0000_0000, 22'd1);
        queue_access(64'h0000_0006_1000_0000, 22'd1);
        queue_access(64'h0000_0006_2000_0000, 22'd1);
        queue_access(64'h0000_0006_1000_0000, 22'd1);
        queue_access(64'h5555_5555_5555_5555, 22'h2AAAAA);
        queue_access(64'hAAAA_AAAA_AAAA_AAAA, 22'h155555);
        wait_drained();

        // zero limit: address zero is mappable
        write_low_limit('0);
        queue_access(64'h0, 22'd1);
        queue_access(64'h0, LEN_TOP);
        run_random(45);
        wait_drained();

        // random mid-range limit, sender idles
        write_low_limit({24'h0, 8'($urandom_range(1, 255)), 32'($urandom)});
        send_idle_pct = 69;
        run_random(45);
        wait_drained();

        // reset limit again, receiver stalls
        write_low_limit(dcmt_pkg::LOW_LIMIT_RESET);
        send_idle_pct  = 0;
        recv_stall_pct = 69;
        run_random(45);
        wait_drained();

        // limit at the top: only the very last address passes
        write_low_limit('1);
        send_idle_pct  = 14;
        recv_stall_pct = 14;
        queue_access(64'hFFFF_FFFF_FFFF_FFFF, 22'd5);
        queue_access(64'hFFFF_FFFF_FFFF_FFFE, 22'd1);
        queue_access(64'h0, 22'd0);
        wait_drained();

        // small limit, both sides idle, sender holds off mid-phase until all results are in
        write_low_limit({48'h0, 16'($urandom_range(1, 16'hFFFF))});
        run_random(25);
        wait_drained();
        run_random(25);
        wait_drained();

        // fill every free slot with fresh chunks
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (slots_used < dcmt_pkg::TABLE_SLOTS) begin
            left = dcmt_pkg::TABLE_SLOTS - slots_used;
            while (left > 0) begin
                n = (left > 63) ? 63 : left;
                queue_access(FILL_BASE + (fill_chunk << dcmt_pkg::CHUNK_SHIFT),
                             dcmt_pkg::LEN_W'(n << dcmt_pkg::CHUNK_SHIFT));
                fill_chunk = fill_chunk + 64'(n);
                left -= n;
            end
            wait_drained();
        end

        // table full: new chunks are refused, stored ones still found
        queue_access(FILL_BASE + (fill_chunk << dcmt_pkg::CHUNK_SHIFT), 22'h20000);
        queue_access(FILL_BASE + ((fill_chunk - 64'd1) << dcmt_pkg::CHUNK_SHIFT), 22'h20000);
        queue_access(64'h0000_0001_0000_0000, 22'd1);
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (!failed) begin
            $display("demand_chunk_map_tracker_core verification clean");
        end else begin
            $display("demand_chunk_map_tracker_core verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/dcmt_pkg.sv
hw/rtl/dcmt_dp.sv
hw/rtl/dcmt_ctrl.sv
hw/rtl/demand_chunk_map_tracker_core.sv
verif/tb_demand_chunk_map_tracker_core.sv
